// File: rtl/core/asd_pkg.sv
// Shared constants, register codes and reset values for the step detector.
package asd_pkg;

   // Fixed-point scaling of the acceleration inputs (Q4.FRAC_BITS g)
   localparam int unsigned FRAC_BITS = 11;
   localparam int unsigned ONE_G     = 1 << FRAC_BITS;

   // Field widths
   localparam int unsigned ACCEL_W   = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned MAG_W     = 17;
   localparam int unsigned ROOT_W    = 16;
   localparam int unsigned SUM_W     = 32;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned OFFSET_W  = 12;
   localparam int unsigned INTV_W    = 16;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 16;

   // Packed stream widths (whole bytes)
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 56;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_OFFSET     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_STEP_INTERVAL_MS = 1'd1;

   // Reset values: 0.1 g offset, 1.2 g and 0.8 g peak seeds, 200 ms interval
   localparam logic [OFFSET_W-1:0] OFFSET_RESET   = OFFSET_W'((ONE_G + 5) / 10);
   localparam logic [MAG_W-1:0]    HIGH_RESET     = MAG_W'((12 * ONE_G + 5) / 10);
   localparam logic [MAG_W-1:0]    LOW_RESET      = MAG_W'((8 * ONE_G + 5) / 10);
   localparam logic [INTV_W-1:0]   INTERVAL_RESET = INTV_W'(200);

   // Square root start weight: highest even power of two in the radicand
   localparam logic [SUM_W-1:0] ROOT_BIT_INIT = SUM_W'(1) << (SUM_W - 2);

endpackage

// File: rtl/core/asd_sqsum.sv
// Sum of squares of three axes through one shared multiplier, one axis a cycle.
module asd_sqsum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [asd_pkg::ACCEL_W-1:0]   accel_x,
   input  logic signed [asd_pkg::ACCEL_W-1:0]   accel_y,
   input  logic signed [asd_pkg::ACCEL_W-1:0]   accel_z,
   output logic                                 done,
   output logic        [asd_pkg::SUM_W-1:0]     sum
);

   localparam int unsigned OP_W = asd_pkg::ACCEL_W + 1;

   // Magnitude of a signed axis value; -32768 needs the extra bit
   function automatic logic [OP_W-1:0] abs_val(input logic signed [asd_pkg::ACCEL_W-1:0] v);
      logic [OP_W-1:0] ext;
      ext = {v[asd_pkg::ACCEL_W-1], v};
      return v[asd_pkg::ACCEL_W-1] ? (OP_W'(0) - ext) : ext;
   endfunction

   logic [OP_W-1:0]             op0_ff, op0_in, op1_ff, op1_in, op2_ff, op2_in;
   logic [1:0]                  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        pv_ff, pv_in;
   logic                        done_ff, done_in;
   logic [asd_pkg::SUM_W-1:0]   prod_ff, prod_in;
   logic [asd_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic [2*OP_W-1:0]           sq_full;

   // The one multiplier: squares the operand at the head of the shift line
   assign sq_full = op0_ff * op0_ff;

   // Sequencer: three products, each accumulated in the cycle after it is registered
   always_comb begin
      op0_in  = op0_ff;
      op1_in  = op1_ff;
      op2_in  = op2_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      pv_in   = 1'b0;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start) begin
         op0_in  = abs_val(accel_x);
         op1_in  = abs_val(accel_y);
         op2_in  = abs_val(accel_z);
         acc_in  = '0;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (pv_ff) begin
            acc_in = acc_ff + prod_ff;
         end
         if (cnt_ff != 2'd3) begin
            // square is at most 2^30, so the low bits hold it exactly
            prod_in = sq_full[asd_pkg::SUM_W-1:0];
            pv_in   = 1'b1;
            op0_in  = op1_ff;
            op1_in  = op2_ff;
            cnt_in  = cnt_ff + 2'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         pv_ff   <= pv_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      op0_ff  <= op0_in;
      op1_ff  <= op1_in;
      op2_ff  <= op2_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

// File: rtl/core/asd_isqrt.sv
// Floored integer square root, two radicand bits per cycle.
module asd_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [asd_pkg::SUM_W-1:0]      radicand,
   output logic                           done,
   output logic [asd_pkg::ROOT_W-1:0]     root
);

   logic [asd_pkg::SUM_W-1:0] rem_ff, rem_in;
   logic [asd_pkg::SUM_W-1:0] res_ff, res_in;
   logic [asd_pkg::SUM_W-1:0] bit_ff, bit_in;
   logic [asd_pkg::SUM_W-1:0] trial;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   // Shared add/compare/subtract unit
   assign trial = res_ff + bit_ff;

   // One digit per cycle; the last step is the one with weight 1
   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = asd_pkg::ROOT_BIT_INIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   // root of a 32-bit value fits 16 bits
   assign root = res_ff[asd_pkg::ROOT_W-1:0];

endmodule

// File: rtl/core/accel_step_detector_unit.sv
// Step detector top level: sequencer, filter, peak tracking and step decision.
//
// Each sample passes from acceptance to result through the shared
// multiply-accumulate for x*x + y*y + z*z, a registered hand-off of the sum
// to the square root unit, the two-bits-per-cycle square root unit, then
// the filter, the peak update and the step decision. req_tready is high
// only while the sequencer is idle, so a new sample is not accepted until
// the previous one has left the step decision. The result sits in an
// output register, so the next sample is accepted while a result still
// waits; if it is not taken by the time the next decision is due, the
// sequencer holds at that step. Write the configuration registers only
// while no sample is in flight.
module accel_step_detector_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [79:48] now_ms
   input  logic [asd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] step_detected, [32:1] step_total, [49:33] filtered_magnitude, rest 0
   output logic [asd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration write port
   input  logic                                csr_wen,
   input  logic [asd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [asd_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SOS,
      ST_ROOT,
      ST_PEAK,
      ST_DECIDE
   } state_type;

   localparam int unsigned FSUM_W = asd_pkg::MAG_W + 2;
   localparam int unsigned THR_W  = asd_pkg::MAG_W + 1;

   state_type                        state_ff, state_in;
   logic [asd_pkg::TIME_W-1:0]       now_ff, now_in;
   logic [asd_pkg::MAG_W-1:0]        filt_ff, filt_in;
   logic [asd_pkg::MAG_W-1:0]        high_ff, high_in;
   logic [asd_pkg::MAG_W-1:0]        low_ff, low_in;
   logic [asd_pkg::TIME_W-1:0]       last_ff, last_in;
   logic [asd_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             gap_ok_ff, gap_ok_in;
   logic [asd_pkg::OFFSET_W-1:0]     thr_off_ff, thr_off_in;
   logic [asd_pkg::INTV_W-1:0]       interval_ff, interval_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_step_ff, rsp_step_in;
   logic [asd_pkg::COUNT_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [asd_pkg::MAG_W-1:0]        rsp_filt_ff, rsp_filt_in;

   logic                             req_acc;
   logic                             sos_done;
   logic [asd_pkg::SUM_W-1:0]        sos_sum;
   logic                             root_done;
   logic [asd_pkg::ROOT_W-1:0]       root;
   logic [FSUM_W-1:0]                filt_sum;
   logic [THR_W-1:0]                 peak_sum;
   logic [THR_W-1:0]                 thr;
   logic [asd_pkg::TIME_W-1:0]       gap;
   logic                             step;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // Shared multiplier: sum of squares
   asd_sqsum u_sqsum (
      .clock   (clock),
      .reset   (reset),
      .start   (req_acc),
      .accel_x (req_tdata[15:0]),
      .accel_y (req_tdata[31:16]),
      .accel_z (req_tdata[47:32]),
      .done    (sos_done),
      .sum     (sos_sum)
   );

   // Iterative root, started as soon as the sum is ready
   asd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sos_done),
      .radicand (sos_sum),
      .done     (root_done),
      .root     (root)
   );

   // Filter (old + 3*new) / 4, threshold and interval arithmetic
   assign filt_sum = {2'b00, filt_ff} + {2'b00, root, 1'b0} + {3'b000, root};
   assign peak_sum = {1'b0, high_ff} + {1'b0, low_ff};
   assign thr      = {1'b0, peak_sum[THR_W-1:1]} + {6'b000000, thr_off_ff};
   assign gap      = now_ff - last_ff;
   assign step     = ({1'b0, filt_ff} > thr) && gap_ok_ff;

   // Sequencer and tracking state
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      filt_in      = filt_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      gap_ok_in    = gap_ok_ff;
      thr_off_in   = thr_off_ff;
      interval_in  = interval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_total_in = rsp_total_ff;
      rsp_filt_in  = rsp_filt_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               now_in   = req_tdata[79:48];
               state_in = ST_SOS;
            end
         end
         ST_SOS: begin
            if (sos_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               filt_in  = filt_sum[FSUM_W-1:2];
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            if (filt_ff > high_ff) begin
               high_in = filt_ff;
            end
            if (filt_ff < low_ff) begin
               low_in = filt_ff;
            end
            gap_ok_in = gap > {16'h0000, interval_ff};
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               if (step) begin
                  count_in = count_ff + 32'd1;
                  last_in  = now_ff;
                  high_in  = filt_ff;
                  low_in   = filt_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_step_in  = step;
               rsp_total_in = step ? (count_ff + 32'd1) : count_ff;
               rsp_filt_in  = filt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes
      if (csr_wen) begin
         case (csr_index)
            asd_pkg::REG_THRESHOLD_OFFSET:     thr_off_in  = csr_wdata[asd_pkg::OFFSET_W-1:0];
            asd_pkg::REG_MIN_STEP_INTERVAL_MS: interval_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // State with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filt_ff      <= '0;
         high_ff      <= asd_pkg::HIGH_RESET;
         low_ff       <= asd_pkg::LOW_RESET;
         last_ff      <= '0;
         count_ff     <= '0;
         thr_off_ff   <= asd_pkg::OFFSET_RESET;
         interval_ff  <= asd_pkg::INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         thr_off_ff   <= thr_off_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      gap_ok_ff    <= gap_ok_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_total_ff <= rsp_total_in;
      rsp_filt_ff  <= rsp_filt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_filt_ff, rsp_total_ff, rsp_step_ff};

endmodule

// File: rtl/core/asd_checker.sv
// Port-level checks for the step detector, bound to the top level.
module asd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [asd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic                          req_acc;
   logic                          rsp_acc;
   logic [asd_pkg::COUNT_W-1:0]   total_ff;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Step total seen on the last delivered transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (rsp_acc) begin
         total_ff <= rsp_tdata[32:1];
      end
   end

   // A stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // One sample in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request accepted while a sample is in work");

   // A result never appears right after a sample is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after acceptance");

   // Step total advances by exactly the step flag
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> rsp_tdata[32:1] == total_ff + {31'd0, rsp_tdata[0]})
      else $error("step total does not follow the step flag");

endmodule

bind accel_step_detector_unit asd_checker u_asd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb_accel_step_detector_unit.sv
// Self-checking testbench for the step detector: gait-like and random samples vs. a predictor.
`timescale 1ns / 100ps

module tb_accel_step_detector_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;

   // One sample as packed on req_tdata, accel_x in the lowest bits
   typedef struct packed {
      logic        [asd_pkg::TIME_W-1:0]  now_ms;
      logic signed [asd_pkg::ACCEL_W-1:0] accel_z;
      logic signed [asd_pkg::ACCEL_W-1:0] accel_y;
      logic signed [asd_pkg::ACCEL_W-1:0] accel_x;
   } accel_sample_type;

   typedef struct {
      logic                        step_detected;
      logic [asd_pkg::COUNT_W-1:0] step_total;
      logic [asd_pkg::MAG_W-1:0]   filtered_magnitude;
   } step_result_type;

   typedef enum int {RSP_ALWAYS, RSP_COIN, RSP_SPARSE, RSP_RHYTHM} rsp_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [79:48] now_ms
   logic [asd_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   // [0] step_detected, [32:1] step_total, [49:33] filtered_magnitude, rest 0
   logic [asd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_wen;
   logic [asd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [asd_pkg::CSR_DAT_W-1:0]  csr_wdata;

   // Predicted detector state and its registers
   logic [asd_pkg::OFFSET_W-1:0]   cfg_offset;
   logic [asd_pkg::INTV_W-1:0]     cfg_interval;
   logic [asd_pkg::MAG_W-1:0]      smooth_mag;
   logic [asd_pkg::MAG_W-1:0]      peak_max;
   logic [asd_pkg::MAG_W-1:0]      peak_min;
   logic [asd_pkg::TIME_W-1:0]     last_step_ms;
   logic [asd_pkg::COUNT_W-1:0]    steps_counted;

   step_result_type                expected_steps[$];
   int                             mismatch_count = 0;
   int                             idle_cycles = 0;
   int                             burst_left = 0;
   int                             rsp_hold_cycles = 0;
   logic [asd_pkg::TIME_W-1:0]     clock_ms = '0;

   accel_step_detector_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Expected outcome of one sample; advances the predicted state
   function automatic step_result_type predict_sample(input accel_sample_type s);
      int                          xi, yi, zi;
      logic [asd_pkg::SUM_W-1:0]   energy;
      logic [asd_pkg::ROOT_W-1:0]  root;
      logic [asd_pkg::ROOT_W-1:0]  trial;
      logic [31:0]                 level;
      step_result_type             r;
      xi = s.accel_x;
      yi = s.accel_y;
      zi = s.accel_z;
      if (xi < 0) xi = -xi;
      if (yi < 0) yi = -yi;
      if (zi < 0) zi = -zi;
      energy = asd_pkg::SUM_W'(longint'(xi) * xi + longint'(yi) * yi + longint'(zi) * zi);
      // floor root, one bit at a time from the top
      root = '0;
      for (int b = asd_pkg::ROOT_W - 1; b >= 0; b--) begin
         trial = root | (asd_pkg::ROOT_W'(1) << b);
         if (32'(trial) * 32'(trial) <= energy) root = trial;
      end
      smooth_mag = asd_pkg::MAG_W'((32'(smooth_mag) + 32'd3 * 32'(root)) >> 2);
      if (smooth_mag > peak_max) peak_max = smooth_mag;
      if (smooth_mag < peak_min) peak_min = smooth_mag;
      level = ((32'(peak_max) + 32'(peak_min)) >> 1) + 32'(cfg_offset);
      r.step_detected = 1'b0;
      if (32'(smooth_mag) > level && (s.now_ms - last_step_ms) > 32'(cfg_interval)) begin
         r.step_detected = 1'b1;
         steps_counted   = steps_counted + 32'd1;
         last_step_ms    = s.now_ms;
         peak_max        = smooth_mag;
         peak_min        = smooth_mag;
      end
      r.step_total         = steps_counted;
      r.filtered_magnitude = smooth_mag;
      return r;
   endfunction

   // Offer one sample in sender bursts; record its expectation on acceptance
   task automatic send_sample(input accel_sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(1, 30);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      req_tdata  <= s;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_steps.push_back(predict_sample(s));
   endtask

   task automatic send_accel(input int x, input int y, input int z, input logic [31:0] t);
      accel_sample_type s;
      s.accel_x = 16'(x);
      s.accel_y = 16'(y);
      s.accel_z = 16'(z);
      s.now_ms  = t;
      send_sample(s);
   endtask

   // Stop offering and wait for every pending result
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [asd_pkg::CSR_DAT_W-1:0] offset_val,
                            input logic [asd_pkg::CSR_DAT_W-1:0] interval_val);
      wait_drained();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= asd_pkg::REG_THRESHOLD_OFFSET;
      csr_wdata <= offset_val;
      @(negedge clock);
      csr_index <= asd_pkg::REG_MIN_STEP_INTERVAL_MS;
      csr_wdata <= interval_val;
      @(negedge clock);
      csr_wen   <= 1'b0;
      cfg_offset   = offset_val[asd_pkg::OFFSET_W-1:0];
      cfg_interval = interval_val[asd_pkg::INTV_W-1:0];
   endtask

   // Gait-like strides with random content, with some noise and broken timing mixed in
   task automatic walk_samples(input int count, input int dt_lo, input int dt_hi);
      accel_sample_type s;
      logic [63:0]      raw;
      int               stride, pos, amp, lvl, axis, one_g;
      one_g  = asd_pkg::ONE_G;
      stride = 1;
      pos    = 0;
      amp    = 0;
      axis   = 2;
      for (int i = 0; i < count; i++) begin
         if (pos == 0) begin
            stride = $urandom_range(4, 14);
            amp    = $urandom_range(200, 7000);
            axis   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 2;
         end
         lvl = (pos < stride / 2) ? one_g + amp : ((one_g > amp) ? one_g - amp : 0);
         if ($urandom_range(0, 1) == 1) lvl = -lvl;
         s.accel_x = 16'(int'($urandom_range(0, 600)) - 300);
         s.accel_y = 16'(int'($urandom_range(0, 600)) - 300);
         s.accel_z = 16'(int'($urandom_range(0, 600)) - 300);
         case (axis)
            0: s.accel_x = 16'(lvl);
            1: s.accel_y = 16'(lvl);
            default: s.accel_z = 16'(lvl);
         endcase
         clock_ms = clock_ms + $urandom_range(dt_lo, dt_hi);
         case ($urandom_range(0, 15))
            0: begin
               raw = {$urandom(), $urandom()};
               s.accel_x = raw[15:0];
               s.accel_y = raw[31:16];
               s.accel_z = raw[47:32];
            end
            1: clock_ms = clock_ms - $urandom_range(0, 500);
            default: ;
         endcase
         s.now_ms = clock_ms;
         send_sample(s);
         pos = (pos + 1) % stride;
      end
   endtask

   // Field extremes, root rounding, interval boundaries and timestamp wrap
   task automatic test_directed();
      send_accel(0, 0, 0, 0);
      send_accel(-32768, -32768, -32768, 100);
      send_accel(32767, 32767, 32767, 200);
      send_accel(32767, -32768, 0, 201);
      send_accel(1, 1, 1, 202);
      send_accel(3, 4, 0, 203);
      send_accel(3, 4, 1, 204);
      send_accel(0, 0, 2048, 300);
      send_accel(0, 0, -2048, 450);
      send_accel(0, -32768, 0, 600);
      send_accel(0, 0, 0, 650);
      send_accel(0, 0, 0, 700);
      send_accel(32767, 32767, 32767, 800);
      send_accel(32767, 32767, 32767, 1000);
      send_accel(32767, 32767, 32767, 1001);
      send_accel(-1, -1, -1, 32'hFFFF_FFFF);
      send_accel(0, 0, 0, 32'hFFFF_FFF0);
      send_accel(-32768, 0, 0, 32'hFFFF_FFFF);
      send_accel(0, 0, 0, 32'hFFFF_FFFF);
      send_accel(32767, 0, 32767, 32'h0000_0010);
      send_accel(0, 0, 0, 32'h0000_0020);
      send_accel(-32768, 32767, -32768, 32'h0000_0200);
      wait_drained();
   endtask

   // Register extremes, including values wider than the offset field
   task automatic test_config_extremes();
      configure(16'h0000, 16'h0000);
      walk_samples(60, 1, 40);
      configure(16'hFFFF, 16'hFFFF);
      walk_samples(60, 4000, 25000);
      configure(16'd4095, 16'h0000);
      walk_samples(60, 0, 30);
      configure(16'h0000, 16'd65535);
      walk_samples(60, 10000, 40000);
      configure(16'(asd_pkg::OFFSET_RESET), 16'(asd_pkg::INTERVAL_RESET));
   endtask

   // Long gait runs under several random settings
   task automatic test_walking();
      for (int p = 0; p < 7; p++) begin
         configure(16'($urandom_range(0, 1200)), 16'($urandom_range(0, 600)));
         walk_samples(100, 5, 60);
      end
   endtask

   // Timestamps that cross the 32-bit wrap during steady walking
   task automatic test_time_wrap();
      configure(16'(asd_pkg::OFFSET_RESET), 16'(asd_pkg::INTERVAL_RESET));
      clock_ms = 32'hFFFF_FE00;
      walk_samples(60, 5, 60);
   endtask

   // Receiver holds off while the sender keeps offering, then a full drain
   task automatic test_backpressure();
      rsp_hold_cycles = 400;
      walk_samples(12, 5, 60);
      wait_drained();
   endtask

   // Fully random samples and timestamps under random register values
   task automatic test_noise();
      accel_sample_type s;
      logic [95:0]      raw;
      configure(16'($urandom()), 16'($urandom()));
      for (int i = 0; i < 200; i++) begin
         raw = {$urandom(), $urandom(), $urandom()};
         s   = raw[asd_pkg::REQ_DATA_W-1:0];
         send_sample(s);
      end
   endtask

   // Receiver: random stall pattern in segments, plus a requested long hold
   initial begin : rsp_stall_pattern
      rsp_mode_type mode;
      int           seg_left;
      int           tick;
      rsp_tready = 1'b0;
      mode       = RSP_ALWAYS;
      seg_left   = 0;
      tick       = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode     = rsp_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(40, 250);
            end
            seg_left--;
            tick++;
            case (mode)
               RSP_ALWAYS: rsp_tready <= 1'b1;
               RSP_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RSP_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
               RSP_RHYTHM: rsp_tready <= ((tick % 7) < 3);
               default:    rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      step_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_steps.size() == 0) begin
            $display("%0t: result with nothing pending: %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_steps.pop_front();
            if (rsp_tdata[0] !== want.step_detected) begin
               $display("%0t: step_detected expected %0d actual %0d",
                        $time, want.step_detected, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[32:1] !== want.step_total) begin
               $display("%0t: step_total expected %0d actual %0d",
                        $time, want.step_total, rsp_tdata[32:1]);
               mismatch_count++;
            end
            if (rsp_tdata[49:33] !== want.filtered_magnitude) begin
               $display("%0t: filtered_magnitude expected %0d actual %0d",
                        $time, want.filtered_magnitude, rsp_tdata[49:33]);
               mismatch_count++;
            end
            if (rsp_tdata[asd_pkg::RSP_DATA_W-1:50] !== '0) begin
               $display("%0t: padding expected 0 actual %h",
                        $time, rsp_tdata[asd_pkg::RSP_DATA_W-1:50]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_wen       = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      cfg_offset    = asd_pkg::OFFSET_RESET;
      cfg_interval  = asd_pkg::INTERVAL_RESET;
      smooth_mag    = '0;
      peak_max      = asd_pkg::HIGH_RESET;
      peak_min      = asd_pkg::LOW_RESET;
      last_step_ms  = '0;
      steps_counted = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_config_extremes();
      test_walking();
      test_time_wrap();
      test_backpressure();
      test_noise();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
